// ===== rtl/binarize_block_count_features_assert.svh =====
// Assertion macros used by the checker of the block count feature extractor.
`ifndef BINARIZE_BLOCK_COUNT_FEATURES_ASSERT_SVH
`define BINARIZE_BLOCK_COUNT_FEATURES_ASSERT_SVH

// Property checked at every rising clock edge outside of reset.
`define BBCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A stalled transfer keeps valid and payload until it is taken.
`define BBCF_ASSERT_HOLD(lbl, vld, rdy, data, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

// ===== rtl/bbcf_pkg.sv =====
package bbcf_pkg;

  localparam int unsigned IMAGE_SIDE_DEF = 32;
  localparam int unsigned CELL_SIDE_DEF  = 4;

  localparam int unsigned PIXEL_W = 8;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned INDEX_W = 6;

  localparam logic [PIXEL_W-1:0] INK_THRESHOLD_RST = 8'd240;

  // Position of the pixel in work, as seen by the accumulator.
  typedef struct packed {
    logic               in_range;
    logic               cell_done;
    logic               last;
    logic [INDEX_W-1:0] index;
  } pos_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [INDEX_W-1:0] index;
    logic               last;
  } cell_res_t;

endpackage

// ===== rtl/bbcf_if.sv =====
interface bbcf_pix_if;
  import bbcf_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_value;
  logic               frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface bbcf_cell_if;
  import bbcf_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] cell_count;
  logic [INDEX_W-1:0] cell_index;
  logic               last_cell;

  modport source (output valid, output cell_count, output cell_index, output last_cell,
                  input ready);
  modport sink   (input valid, input cell_count, input cell_index, input last_cell,
                  output ready);
endinterface

// ===== rtl/bbcf_pos_track.sv =====
module bbcf_pos_track #(
  parameter int unsigned IMAGE_SIDE = bbcf_pkg::IMAGE_SIDE_DEF,
  parameter int unsigned CELL_SIDE  = bbcf_pkg::CELL_SIDE_DEF,
  localparam int unsigned CELLS  = IMAGE_SIDE / CELL_SIDE,
  localparam int unsigned CCOL_W = $clog2(CELLS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              clear_i,
  output logic [CCOL_W-1:0] cell_col_o,
  output bbcf_pkg::pos_t    pos_o
);
  import bbcf_pkg::*;

  localparam int unsigned POS_W = $clog2(IMAGE_SIDE);
  localparam int unsigned OFF_W = (CELL_SIDE > 1) ? $clog2(CELL_SIDE) : 1;

  logic [POS_W-1:0]  col_q, col_d, row_q, row_d;
  logic [OFF_W-1:0]  col_off_q, col_off_d, row_off_q, row_off_d;
  logic [CCOL_W-1:0] ccol_q, ccol_d, crow_q, crow_d;

  logic [POS_W-1:0]  col_c, row_c;
  logic [OFF_W-1:0]  col_off_c, row_off_c;
  logic [CCOL_W-1:0] ccol_c, crow_c;
  logic              col_off_end, row_off_end;

  // Frame start places the current pixel at the origin.
  always_comb begin
    col_c     = clear_i ? '0 : col_q;
    row_c     = clear_i ? '0 : row_q;
    col_off_c = clear_i ? '0 : col_off_q;
    row_off_c = clear_i ? '0 : row_off_q;
    ccol_c    = clear_i ? '0 : ccol_q;
    crow_c    = clear_i ? '0 : crow_q;
  end

  assign col_off_end = (col_off_c == OFF_W'(CELL_SIDE - 1));
  assign row_off_end = (row_off_c == OFF_W'(CELL_SIDE - 1));

  always_comb begin
    pos_o.in_range  = (ccol_c < CCOL_W'(CELLS)) && (crow_c < CCOL_W'(CELLS));
    pos_o.cell_done = pos_o.in_range && col_off_end && row_off_end;
    pos_o.last      = (ccol_c == CCOL_W'(CELLS - 1)) && (crow_c == CCOL_W'(CELLS - 1));
    pos_o.index     = INDEX_W'(32'(crow_c) * 32'(CELLS) + 32'(ccol_c));
  end

  assign cell_col_o = ccol_c;

  always_comb begin
    col_d     = col_c + POS_W'(1);
    col_off_d = col_off_end ? '0 : col_off_c + OFF_W'(1);
    ccol_d    = ccol_c + CCOL_W'(col_off_end);
    row_d     = row_c;
    row_off_d = row_off_c;
    crow_d    = crow_c;
    if (col_c == POS_W'(IMAGE_SIDE - 1)) begin
      col_d     = '0;
      col_off_d = '0;
      ccol_d    = '0;
      if (row_c == POS_W'(IMAGE_SIDE - 1)) begin
        row_d     = '0;
        row_off_d = '0;
        crow_d    = '0;
      end else begin
        row_d     = row_c + POS_W'(1);
        row_off_d = row_off_end ? '0 : row_off_c + OFF_W'(1);
        crow_d    = crow_c + CCOL_W'(row_off_end);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      col_off_q <= '0;
      row_off_q <= '0;
      ccol_q    <= '0;
      crow_q    <= '0;
    end else if (step_i) begin
      col_q     <= col_d;
      row_q     <= row_d;
      col_off_q <= col_off_d;
      row_off_q <= row_off_d;
      ccol_q    <= ccol_d;
      crow_q    <= crow_d;
    end
  end

endmodule

// ===== rtl/bbcf_cell_acc.sv =====
module bbcf_cell_acc #(
  parameter int unsigned IMAGE_SIDE = bbcf_pkg::IMAGE_SIDE_DEF,
  parameter int unsigned CELL_SIDE  = bbcf_pkg::CELL_SIDE_DEF,
  localparam int unsigned CELLS  = IMAGE_SIDE / CELL_SIDE,
  localparam int unsigned CCOL_W = $clog2(CELLS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                clear_i,
  input  logic                ink_i,
  input  logic [CCOL_W-1:0]   cell_col_i,
  input  bbcf_pkg::pos_t      pos_i,
  output logic                res_valid_o,
  output bbcf_pkg::cell_res_t res_o
);
  import bbcf_pkg::*;

  localparam int unsigned ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [COUNT_W-1:0] sums_q [CELLS];
  logic [ADDR_W-1:0]  addr;
  logic [COUNT_W-1:0] rd_sum, sum;

  assign addr   = cell_col_i[ADDR_W-1:0];
  assign rd_sum = clear_i ? '0 : sums_q[addr];
  assign sum    = rd_sum + COUNT_W'(ink_i);

  assign res_valid_o = pos_i.cell_done;
  assign res_o.count = sum;
  assign res_o.index = pos_i.index;
  assign res_o.last  = pos_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) begin
        sums_q[i] <= '0;
      end
    end else if (step_i) begin
      for (int i = 0; i < CELLS; i++) begin
        // Finished cell frees its column for the next cell row.
        if (pos_i.in_range && (addr == ADDR_W'(i))) begin
          sums_q[i] <= pos_i.cell_done ? '0 : sum;
        end else if (clear_i) begin
          sums_q[i] <= '0;
        end
      end
    end
  end

endmodule

// ===== rtl/binarize_block_count_features.sv =====
// An accepted pixel is held in s1; its cell result then goes into the output register.
// Throughput: one pixel per cycle unless a result waits for cell_o.ready; the
// position counters and per-column sums step together; the next pixel follows at once.
// Reset: asynchronous, active low; clears position, cell sums and valid flags,
// and sets the ink threshold to 240.
module binarize_block_count_features #(
  parameter int unsigned IMAGE_SIDE = bbcf_pkg::IMAGE_SIDE_DEF,
  parameter int unsigned CELL_SIDE  = bbcf_pkg::CELL_SIDE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbcf_pkg::PIXEL_W-1:0]   cfg_wdata_i,
  bbcf_pix_if.sink                       pix_i,
  bbcf_cell_if.source                    cell_o
);
  import bbcf_pkg::*;

  localparam int unsigned CELLS  = IMAGE_SIDE / CELL_SIDE;
  localparam int unsigned CCOL_W = $clog2(CELLS + 1);

  logic [PIXEL_W-1:0] thr_q;
  logic               s1_valid_q, s1_valid_d;
  logic [PIXEL_W-1:0] s1_pix_q;
  logic               s1_fs_q;
  logic               out_valid_q, out_valid_d;
  cell_res_t          out_res_q;

  logic               in_xfer, out_free, s1_fire, ink;
  logic [CCOL_W-1:0]  cell_col;
  pos_t               pos;
  logic               res_valid;
  cell_res_t          res;

  assign out_free    = !out_valid_q || cell_o.ready;
  assign s1_fire     = s1_valid_q && out_free;
  assign pix_i.ready = !s1_valid_q || out_free;
  assign in_xfer     = pix_i.valid && pix_i.ready;
  assign ink         = (s1_pix_q <= thr_q);

  bbcf_pos_track #(
    .IMAGE_SIDE (IMAGE_SIDE),
    .CELL_SIDE  (CELL_SIDE)
  ) u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_fire),
    .clear_i    (s1_fs_q),
    .cell_col_o (cell_col),
    .pos_o      (pos)
  );

  bbcf_cell_acc #(
    .IMAGE_SIDE (IMAGE_SIDE),
    .CELL_SIDE  (CELL_SIDE)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_fire),
    .clear_i     (s1_fs_q),
    .ink_i       (ink),
    .cell_col_i  (cell_col),
    .pos_i       (pos),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && res_valid) begin
      out_valid_d = 1'b1;
    end else if (cell_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= INK_THRESHOLD_RST;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pix_q <= pix_i.pixel_value;
      s1_fs_q  <= pix_i.frame_start;
    end
    if (s1_fire && res_valid) begin
      out_res_q <= res;
    end
  end

  assign cell_o.valid      = out_valid_q;
  assign cell_o.cell_count = out_res_q.count;
  assign cell_o.cell_index = out_res_q.index;
  assign cell_o.last_cell  = out_res_q.last;

endmodule

// ===== rtl/bbcf_checker.sv =====
`include "binarize_block_count_features_assert.svh"

module bbcf_checker #(
  parameter int unsigned IMAGE_SIDE = bbcf_pkg::IMAGE_SIDE_DEF,
  parameter int unsigned CELL_SIDE  = bbcf_pkg::CELL_SIDE_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [bbcf_pkg::COUNT_W-1:0] cell_count_i,
  input logic [bbcf_pkg::INDEX_W-1:0] cell_index_i,
  input logic                         last_cell_i
);
  import bbcf_pkg::*;

  localparam int unsigned CELLS     = IMAGE_SIDE / CELL_SIDE;
  localparam int unsigned CELL_AREA = CELL_SIDE * CELL_SIDE;
  localparam int unsigned NUM_CELLS = CELLS * CELLS;

  logic [COUNT_W+INDEX_W:0] out_data;
  logic                     area_fits, cells_fit;

  assign out_data  = {cell_count_i, cell_index_i, last_cell_i};
  assign area_fits = (CELL_AREA < (1 << COUNT_W));
  assign cells_fit = (NUM_CELLS <= (1 << INDEX_W));

  `BBCF_ASSERT_HOLD(a_out_hold, out_valid_i, out_ready_i, out_data, "result changed while stalled")
  `BBCF_ASSERT(a_count_max, out_valid_i && area_fits |-> cell_count_i <= COUNT_W'(CELL_AREA), "cell count above cell area")
  `BBCF_ASSERT(a_index_max, out_valid_i && cells_fit |-> 32'(cell_index_i) < NUM_CELLS, "cell index beyond image")
  `BBCF_ASSERT(a_last_idx, out_valid_i && last_cell_i |-> cell_index_i == INDEX_W'(NUM_CELLS - 1), "last cell flag on wrong index")

endmodule

bind binarize_block_count_features bbcf_checker #(
  .IMAGE_SIDE (IMAGE_SIDE),
  .CELL_SIDE  (CELL_SIDE)
) u_bbcf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (cell_o.valid),
  .out_ready_i  (cell_o.ready),
  .cell_count_i (cell_o.cell_count),
  .cell_index_i (cell_o.cell_index),
  .last_cell_i  (cell_o.last_cell)
);

// ===== tb/tb_binarize_block_count_features.sv =====
`timescale 1ns / 100ps

module tb_binarize_block_count_features;
  import bbcf_pkg::*;

  localparam int unsigned IMAGE_SIDE    = IMAGE_SIDE_DEF;
  localparam int unsigned CELL_SIDE     = CELL_SIDE_DEF;
  localparam int unsigned CELLS_PER_ROW = IMAGE_SIDE / CELL_SIDE;
  localparam int unsigned CELL_ROW_PIX  = CELL_SIDE * IMAGE_SIDE;
  localparam int unsigned MAX_REPORTS   = 10;

  // Tracks scan position and per-column ink sums, queues the cell counts
  // the block must produce and checks them in order.
  class block_count_tracker;
    bit [PIXEL_W-1:0] threshold = INK_THRESHOLD_RST;
    int unsigned      col_pos;
    int unsigned      row_pos;
    bit [COUNT_W-1:0] col_sums [CELLS_PER_ROW];
    cell_res_t        expected_cells [$];
    int unsigned      mismatches;

    function int unsigned pending();
      return expected_cells.size();
    endfunction

    function void take_pixel(bit [PIXEL_W-1:0] pixel, bit start);
      int unsigned      cell_col;
      int unsigned      cell_row;
      bit [COUNT_W-1:0] sum;
      cell_res_t        res;
      if (start) begin
        col_pos = 0;
        row_pos = 0;
        foreach (col_sums[i]) col_sums[i] = '0;
      end
      cell_col = col_pos / CELL_SIDE;
      cell_row = row_pos / CELL_SIDE;
      if (cell_col < CELLS_PER_ROW && cell_row < CELLS_PER_ROW) begin
        sum = col_sums[cell_col] + COUNT_W'(pixel <= threshold);
        if (col_pos % CELL_SIDE == CELL_SIDE - 1 && row_pos % CELL_SIDE == CELL_SIDE - 1) begin
          res.count = sum;
          res.index = INDEX_W'(cell_row * CELLS_PER_ROW + cell_col);
          res.last  = (cell_row == CELLS_PER_ROW - 1) && (cell_col == CELLS_PER_ROW - 1);
          expected_cells.insert(expected_cells.size(), res);
          col_sums[cell_col] = '0;
        end else begin
          col_sums[cell_col] = sum;
        end
      end
      // advance in raster order, wrap at the bottom-right pixel
      if (col_pos + 1 >= IMAGE_SIDE) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= IMAGE_SIDE) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    endfunction

    function void check_cell(logic [COUNT_W-1:0] count, logic [INDEX_W-1:0] index,
                             logic last);
      cell_res_t want;
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: cell with none pending: count %0d index %0d last %0b",
                   $time, count, index, last);
        return;
      end
      want = expected_cells.pop_front();
      if (count !== want.count || index !== want.index || last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: expected count/index/last %0d/%0d/%0b, got %0d/%0d/%0b",
                   $time, want.count, want.index, want.last, count, index, last);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [PIXEL_W-1:0] cfg_wdata;

  bbcf_pix_if  pix_if ();
  bbcf_cell_if cell_if ();

  block_count_tracker sb;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;

  binarize_block_count_features dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix_if),
    .cell_o      (cell_if)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    cell_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cell_if.valid && cell_if.ready)
        sb.check_cell(cell_if.cell_count, cell_if.cell_index, cell_if.last_cell);
      if (pix_if.valid && pix_if.ready)
        sb.take_pixel(pix_if.pixel_value, pix_if.frame_start);
    end
  end

  // Biased toward the threshold edges and the extremes; otherwise ink with the
  // given probability.
  function automatic logic [PIXEL_W-1:0] pick_pixel(int unsigned ink_pct);
    logic [PIXEL_W-1:0] thr;
    int unsigned        r;
    thr = sb.threshold;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 26) return thr;
    if (r < 36) return thr + 8'd1;
    if ($urandom_range(99) < ink_pct) return PIXEL_W'($urandom_range(thr, 0));
    if (thr == 8'hFF) return thr;
    return PIXEL_W'($urandom_range(255, thr + 1));
  endfunction

  task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      pix_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    pix_if.valid       <= 1'b1;
    pix_if.pixel_value <= pixel;
    pix_if.frame_start <= start;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
  endtask

  // A rare frame start inside the image breaks the sequence on purpose.
  task automatic send_image(input int unsigned n_pixels, input bit with_start);
    int unsigned ink_pct;
    logic        start;
    ink_pct = 0;
    for (int unsigned p = 0; p < n_pixels; p++) begin
      if (p % CELL_ROW_PIX == 0) ink_pct = 25 * $urandom_range(4);
      start = (p == 0) ? with_start : ($urandom_range(599) == 0);
      send_pixel(pick_pixel(ink_pct), start);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    for (int n = 0; n < 5000 && sb.pending() != 0; n++) @(negedge clk_i);
  endtask

  task automatic set_threshold(input logic [PIXEL_W-1:0] value);
    wait_drained();
    // let the last pixel without a result leave the pipeline
    repeat (4) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.threshold = value;
  endtask

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned split;
    sb = new;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    pix_if.valid        = 1'b0;
    pix_if.pixel_value  = '0;
    pix_if.frame_start  = 1'b0;
    send_idle_pct       = 12;
    recv_idle_pct       = 76;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // threshold edges at reset value, alternating bits, repeated frame starts
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd240, 1'b0);
    send_pixel(8'd241, 1'b0);
    send_pixel(8'd239, 1'b0);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'd1, 1'b1);
    send_pixel(8'd254, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b1);
    send_pixel(8'd127, 1'b0);

    send_image(CELL_ROW_PIX, 1'b1);
    set_threshold(8'd0);
    send_image($urandom_range(40, 20), 1'b1);

    wait_drained();
    send_idle_pct = 76;
    recv_idle_pct = 12;
    set_threshold(8'd255);
    send_image(CELL_ROW_PIX, 1'b1);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_threshold(PIXEL_W'($urandom_range(254, 1)));
    split = $urandom_range(90, 30);
    send_image(split, 1'b1);
    // hold the stream until every pending cell is out, then resume mid-image
    wait_drained();
    send_image(CELL_ROW_PIX - split, 1'b0);

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
